>>> hdl/dcta_pkg.sv
// ----------------------------------------------------------------------------
// dcta_pkg
// Shared constants and types of the dual-channel time-of-flight averager.
// ----------------------------------------------------------------------------
`default_nettype none

package dcta_pkg;

  localparam int WINDOW     = 100;
  localparam int STAMP_W    = 16;
  localparam int SUM_W      = 23;
  localparam int IDX_W      = $clog2(WINDOW);
  localparam int RING_DEPTH = 2 * WINDOW;
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  // divide by WINDOW as multiply by rounded-up reciprocal, exact for SUM_W-bit sums
  localparam int              DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int              MULT_W    = SUM_W + 1;
  localparam longint unsigned DIV_MULT  =
    ((64'd1 << DIV_SHIFT) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
  localparam int              PROD_W    = SUM_W + MULT_W;

  localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(WINDOW - 1);
  localparam logic [ADDR_W-1:0] HIGH_BASE   = ADDR_W'(WINDOW);
  localparam logic [MULT_W-1:0] DIV_MULT_C  = MULT_W'(DIV_MULT);

  typedef enum logic {
    ACT_STAMPS = 1'b0,
    ACT_WIDTH  = 1'b1
  } action_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [STAMP_W-1:0] data;
  } ring_wr_t;

endpackage

`default_nettype wire

>>> hdl/dcta_if.sv
// ----------------------------------------------------------------------------
// dcta_if
// Capture and result channel interfaces of the time-of-flight averager.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcta_capture_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] start_stamp;
  logic [15:0] stop_stamp;
  logic [15:0] measured_width;
  logic        channel;

  modport source (output valid, action, start_stamp, stop_stamp, measured_width, channel,
                  input ready);
  modport sink   (input valid, action, start_stamp, stop_stamp, measured_width, channel,
                  output ready);
endinterface

interface dcta_result_if;
  logic        valid;
  logic        ready;
  logic        channel_out;
  logic [15:0] flight_ticks;
  logic        average_valid;
  logic [15:0] average_ticks;

  modport source (output valid, channel_out, flight_ticks, average_valid, average_ticks,
                  input ready);
  modport sink   (input valid, channel_out, flight_ticks, average_valid, average_ticks,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/dcta_ring.sv
// ----------------------------------------------------------------------------
// dcta_ring
// Sample store of both channels: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcta_ring
  import dcta_pkg::*;
(
  input  wire logic               clk,
  input  wire ring_wr_t           wr,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [STAMP_W-1:0] rd_data
);

  logic [STAMP_W-1:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/dual_channel_tof_averager.sv
// ----------------------------------------------------------------------------
// dual_channel_tof_averager
// Time-of-flight capture with a per-channel moving average over WINDOW samples.
//
// Usage:
//   capture: one word per event; action selects stamp pair (stop - start,
//            modulo 65536) or measured width, channel selects the ring.
//   result : one word per event: channel, flight time, ring-filled flag and
//            the truncated mean of the channel ring (zero until filled).
//   Throughput one word per cycle while the receiver takes results. Stage 1
//   reads the old ring sample on capture accept, stage 2 updates the running
//   sum and writes the ring, and the output register takes the sum divided
//   by WINDOW through a reciprocal multiply.
//   Each stage holds its word while the next one is full, so a stalled
//   receiver fills the pipeline and then drops capture ready; nothing is
//   lost or repeated.
//   Reset empties the pipeline and clears ring indices, sums and filled
//   flags at once; the old sample is ignored until a ring has filled, so
//   the sample store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_channel_tof_averager
  import dcta_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  dcta_capture_if.sink   capture,
  dcta_result_if.source  result
);

  logic [IDX_W-1:0] write_index [2];
  logic [SUM_W-1:0] running_sum [2];
  logic             ring_full   [2];

  // stage 1
  logic               v1;
  logic               ch1;
  logic [STAMP_W-1:0] flight1;
  logic               full_old1;
  logic               full_new1;
  logic [ADDR_W-1:0]  addr1;
  logic [STAMP_W-1:0] old_sample;

  // stage 2
  logic               v2;
  logic               ch2;
  logic [STAMP_W-1:0] flight2;
  logic               full2;
  logic [SUM_W-1:0]   sum2;

  // output
  logic               vo;

  logic adv1;
  logic adv2;
  logic accept;

  logic               in_ch;
  logic [STAMP_W-1:0] in_flight;
  logic [IDX_W-1:0]   in_idx;
  logic               in_wrap;
  logic [ADDR_W-1:0]  in_addr;
  logic [SUM_W-1:0]   sum_next;
  logic [PROD_W-1:0]  prod;
  ring_wr_t           ring_wr;

  assign adv2   = v2 && (!vo || result.ready);
  assign adv1   = v1 && (!v2 || adv2);
  assign capture.ready = !v1 || adv1;
  assign accept = capture.valid && capture.ready;

  always_comb begin
    in_ch     = capture.channel;
    in_flight = (action_t'(capture.action) == ACT_WIDTH)
              ? capture.measured_width
              : capture.stop_stamp - capture.start_stamp;
    in_idx    = write_index[in_ch];
    in_wrap   = (in_idx == IDX_LAST);
    in_addr   = in_ch ? HIGH_BASE + ADDR_W'(in_idx) : ADDR_W'(in_idx);
  end

  always_comb begin
    sum_next = running_sum[ch1]
             - (full_old1 ? SUM_W'(old_sample) : '0)
             + SUM_W'(flight1);
    ring_wr.en   = adv1;
    ring_wr.addr = addr1;
    ring_wr.data = flight1;
  end

  assign prod = PROD_W'(sum2) * PROD_W'(DIV_MULT_C);

  dcta_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (old_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vo <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        write_index[c] <= '0;
        running_sum[c] <= '0;
        ring_full[c]   <= 1'b0;
      end
    end else begin
      if (accept) begin
        write_index[in_ch] <= in_wrap ? '0 : in_idx + 1'b1;
        if (in_wrap) begin
          ring_full[in_ch] <= 1'b1;
        end
      end
      if (capture.ready) begin
        v1 <= capture.valid;
      end
      if (adv1) begin
        running_sum[ch1] <= sum_next;
      end
      if (!v2 || adv2) begin
        v2 <= adv1;
      end
      if (!vo || result.ready) begin
        vo <= adv2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch1       <= in_ch;
      flight1   <= in_flight;
      full_old1 <= ring_full[in_ch];
      full_new1 <= ring_full[in_ch] || in_wrap;
      addr1     <= in_addr;
    end
    if (adv1) begin
      ch2     <= ch1;
      flight2 <= flight1;
      full2   <= full_new1;
      sum2    <= sum_next;
    end
    if (adv2) begin
      result.channel_out   <= ch2;
      result.flight_ticks  <= flight2;
      result.average_valid <= full2;
      result.average_ticks <= full2 ? prod[DIV_SHIFT +: STAMP_W] : '0;
    end
  end

  assign result.valid = vo;

endmodule

`default_nettype wire
